// File: design/sart_pkg.sv
// ----------------------------------------------------------------------------
// sart_pkg
// Shared types and constants of the sorted address range table.
// ----------------------------------------------------------------------------
package sart_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = 32;
  localparam int HANDLE_W    = 32;
  localparam int ENTRIES_W   = 11;

  localparam logic [3:0] FUNC_TYPE = 4'd2;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_ALT    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEARED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_SKIPPED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   start;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

endpackage

// File: design/sorted_address_range_table.sv
// ----------------------------------------------------------------------------
// sorted_address_range_table
// Address-ordered table of (start, name handle) entries with clear, insert and
// range lookup.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one request: clear,
//   insert or look up (action 3 acts as a look up). The output channel
//   (out_valid / out_stall) returns one result per request, in order.
//   Requests are worked one at a time; in_stall is high while one is busy.
//   Clear, skipped insert and full insert go straight to the done state.
//   A look up runs a binary search of P probes (about ceil(log2(n+1)),
//   at most 11 for a full table). An insert runs the same search, then
//   moves M entries up one slot, then places the new entry.
//   Each probe issues the memory read, then compares the registered read
//   data. Each moved entry costs one read and one write of the
//   single-port-pair entry memory.
//   A finished result sits in the output register; the next request is
//   accepted meanwhile, and its result waits in the done state while the
//   receiver stalls.
//   Reset empties the table (entry count to zero) and drops any pending
//   result; memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_address_range_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  symbol_info,
  input  logic [31:0] symbol_address,
  input  logic [31:0] name_offset,
  input  logic [31:0] query_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] found_name_offset,
  output logic [31:0] found_start,
  output logic [10:0] entries_held
);

  localparam int CW = sart_pkg::CNT_W;
  localparam int IW = sart_pkg::IDX_W;

  // Control state
  sart_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;

  // Request and search registers
  logic                               req_insert, req_insert_next;
  logic [sart_pkg::ADDR_W-1:0]        req_key, req_key_next;
  logic [sart_pkg::HANDLE_W-1:0]      req_handle, req_handle_next;
  logic [CW-1:0]                      lo, lo_next;
  logic [CW-1:0]                      hi, hi_next;
  logic [CW-1:0]                      mid, mid_next;
  logic [CW-1:0]                      sh, sh_next;
  sart_pkg::entry_t                   cand, cand_next;

  // Pending result
  sart_pkg::status_t                  res_status, res_status_next;
  sart_pkg::entry_t                   res_entry, res_entry_next;
  logic                               load_out;

  // Memory ports
  sart_pkg::ram_wr_t wr;
  sart_pkg::ram_rd_t rd;
  sart_pkg::entry_t  rd_data;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_calc;
  logic [CW-1:0] sh_dec;
  logic          accept;

  sart_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign in_stall = (state != sart_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_calc = mid_sum[CW:1];
  assign sh_dec   = sh - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sart_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    req_insert <= req_insert_next;
    req_key    <= req_key_next;
    req_handle <= req_handle_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    sh         <= sh_next;
    cand       <= cand_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    req_insert_next = req_insert;
    req_key_next    = req_key;
    req_handle_next = req_handle;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    sh_next         = sh;
    cand_next       = cand;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    load_out        = 1'b0;
    wr              = '0;
    rd              = '0;

    case (state)
      sart_pkg::S_IDLE: begin
        if (accept) begin
          req_insert_next = 1'b0;
          req_handle_next = name_offset;
          req_key_next    = query_address;
          lo_next         = '0;
          hi_next         = count;
          res_entry_next  = '0;
          case (sart_pkg::action_t'(action))
            sart_pkg::ACT_CLEAR: begin
              count_next      = '0;
              res_status_next = sart_pkg::ST_CLEARED;
              state_next      = sart_pkg::S_DONE;
            end
            sart_pkg::ACT_INSERT: begin
              req_key_next    = symbol_address;
              req_insert_next = 1'b1;
              if (symbol_info[3:0] != sart_pkg::FUNC_TYPE) begin
                res_status_next = sart_pkg::ST_SKIPPED;
                state_next      = sart_pkg::S_DONE;
              end else if (count == CW'(sart_pkg::TABLE_DEPTH)) begin
                res_status_next = sart_pkg::ST_FULL;
                state_next      = sart_pkg::S_DONE;
              end else begin
                state_next = sart_pkg::S_PROBE;
              end
            end
            default: begin
              state_next = sart_pkg::S_PROBE;
            end
          endcase
        end
      end

      sart_pkg::S_PROBE: begin
        if (lo < hi) begin
          // Read the midpoint; compare next cycle
          mid_next   = mid_calc;
          rd.en      = 1'b1;
          rd.addr    = mid_calc[IW-1:0];
          state_next = sart_pkg::S_COMPARE;
        end else if (req_insert) begin
          // lo is the insert slot; move the tail up from the top
          sh_next    = count;
          state_next = sart_pkg::S_SHIFT_RD;
        end else begin
          if (lo == '0 || lo >= count) begin
            res_status_next = sart_pkg::ST_NOT_FOUND;
          end else begin
            res_status_next = sart_pkg::ST_FOUND;
            res_entry_next  = cand;
          end
          state_next = sart_pkg::S_DONE;
        end
      end

      sart_pkg::S_COMPARE: begin
        // Last entry at or below the key is always the last true probe
        if (rd_data.start <= req_key) begin
          lo_next   = mid + CW'(1);
          cand_next = rd_data;
        end else begin
          hi_next = mid;
        end
        state_next = sart_pkg::S_PROBE;
      end

      sart_pkg::S_SHIFT_RD: begin
        if (sh > lo) begin
          rd.en      = 1'b1;
          rd.addr    = sh_dec[IW-1:0];
          state_next = sart_pkg::S_SHIFT_WR;
        end else begin
          state_next = sart_pkg::S_PLACE;
        end
      end

      sart_pkg::S_SHIFT_WR: begin
        wr.en      = 1'b1;
        wr.addr    = sh[IW-1:0];
        wr.data    = rd_data;
        sh_next    = sh_dec;
        state_next = sart_pkg::S_SHIFT_RD;
      end

      sart_pkg::S_PLACE: begin
        wr.en              = 1'b1;
        wr.addr            = lo[IW-1:0];
        wr.data.start      = req_key;
        wr.data.handle     = req_handle;
        count_next         = count + CW'(1);
        res_status_next    = sart_pkg::ST_INSERTED;
        state_next         = sart_pkg::S_DONE;
      end

      sart_pkg::S_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = sart_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = sart_pkg::S_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status            <= res_status;
      found_name_offset <= res_entry.handle;
      found_start       <= res_entry.start;
      entries_held      <= sart_pkg::ENTRIES_W'(count);
    end
  end

endmodule

// File: design/sart_ram.sv
// ----------------------------------------------------------------------------
// sart_ram
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sart_ram (
  input  logic              clk,
  input  sart_pkg::ram_wr_t wr,
  input  sart_pkg::ram_rd_t rd,
  output sart_pkg::entry_t  rd_data
);

  sart_pkg::entry_t mem [sart_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule
